/* rtl/i2c_master_transfer_sequencer_assert.svh */
// Assertion macros for the I2C master transfer sequencer checker.
// No dependencies; included by the checker file.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_ASSERT_SVH

// Plain property under clock and active-low reset.
`define I2CMTS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("i2cmts check failed: %m");

// Same-cycle implication.
`define I2CMTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cmts implication failed: %m");

// Next-cycle implication.
`define I2CMTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cmts next-cycle check failed: %m");

`endif

/* rtl/i2cmts_pkg.sv */
// Shared types and codes of the I2C master transfer sequencer.
// No dependencies.
`default_nettype none

package i2cmts_pkg;

  localparam int LENGTH_BITS = 16;

  // Transfer phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_WRITE = 2'd1;
  localparam logic [1:0] PH_READ  = 2'd2;

  // Action codes
  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_ADDR      = 3'd1;
  localparam logic [2:0] ACT_DATA      = 3'd2;
  localparam logic [2:0] ACT_ACK       = 3'd3;
  localparam logic [2:0] ACT_NACK_STOP = 3'd4;
  localparam logic [2:0] ACT_STOP      = 3'd5;

  // Error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_BUS  = 2'd1;
  localparam logic [1:0] ERR_NAK  = 2'd2;

  localparam logic [0:0] KIND_START = 1'b0;

  typedef logic [LENGTH_BITS-1:0] len_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [6:0] saved_address;
    len_t       write_total;
    len_t       read_total;
    len_t       write_index;
    len_t       read_index;
    logic [1:0] last_error;
  } seq_state_t;

  localparam seq_state_t STATE_RESET = '{
    phase: PH_IDLE, saved_address: 7'd0, write_total: '0, read_total: '0,
    write_index: '0, read_index: '0, last_error: ERR_NONE};

  typedef struct packed {
    logic [0:0]  kind;
    logic [6:0]  target_address;
    logic [15:0] write_length;
    logic [15:0] read_length;
    logic        read_first;
    logic        arbitration_lost;
    logic        bus_fault;
    logic        got_nack;
    logic [7:0]  received_byte;
    logic [7:0]  next_write_byte;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  action;
    logic [7:0]  address_byte;
    logic [7:0]  data_out;
    logic [7:0]  data_in;
    logic [15:0] byte_index;
    logic [1:0]  error_code;
    logic        done_res;
  } result_t;

endpackage

`default_nettype wire

/* rtl/i2cmts_decide.sv */
// Per-word decision logic: next sequencer state and result word.
// Depends on i2cmts_pkg.
`default_nettype none

module i2cmts_decide (
  input  var i2cmts_pkg::seq_state_t st,
  input  var i2cmts_pkg::item_t      item,
  output i2cmts_pkg::seq_state_t     st_nxt,
  output i2cmts_pkg::result_t        res
);

  localparam i2cmts_pkg::len_t LEN_ONE = i2cmts_pkg::len_t'(1);

  logic              idle;
  logic              start_ok;
  i2cmts_pkg::len_t  wl;
  i2cmts_pkg::len_t  rl;

  assign wl       = i2cmts_pkg::len_t'(item.write_length);
  assign rl       = i2cmts_pkg::len_t'(item.read_length);
  assign idle     = (st.phase != i2cmts_pkg::PH_WRITE) && (st.phase != i2cmts_pkg::PH_READ);
  assign start_ok = idle && !(item.read_first && (rl == '0));

  always_comb begin
    st_nxt = st;
    res    = '0;
    if (item.kind == i2cmts_pkg::KIND_START) begin
      if (start_ok) begin
        st_nxt.saved_address = item.target_address;
        st_nxt.write_total   = wl;
        st_nxt.read_total    = rl;
        st_nxt.write_index   = '0;
        st_nxt.read_index    = '0;
        st_nxt.last_error    = i2cmts_pkg::ERR_NONE;
        st_nxt.phase         = item.read_first ? i2cmts_pkg::PH_READ : i2cmts_pkg::PH_WRITE;
        res.accepted         = 1'b1;
        res.action           = i2cmts_pkg::ACT_ADDR;
        res.address_byte     = {item.target_address, item.read_first};
      end
    end else if (item.arbitration_lost || item.bus_fault || item.got_nack) begin
      // bus faults take priority over NACK
      st_nxt.last_error = (item.arbitration_lost || item.bus_fault) ?
                          i2cmts_pkg::ERR_BUS : i2cmts_pkg::ERR_NAK;
      st_nxt.phase      = i2cmts_pkg::PH_IDLE;
      res.action        = i2cmts_pkg::ACT_STOP;
      res.done_res      = 1'b1;
    end else begin
      unique case (st.phase)
        i2cmts_pkg::PH_WRITE: begin
          if (st.write_index == st.write_total) begin
            if (st.read_total != '0) begin
              // repeated start into the read phase
              res.action        = i2cmts_pkg::ACT_ADDR;
              res.address_byte  = {st.saved_address, 1'b1};
              st_nxt.read_index = '0;
              st_nxt.phase      = i2cmts_pkg::PH_READ;
            end else begin
              res.action        = i2cmts_pkg::ACT_STOP;
              res.done_res      = 1'b1;
              st_nxt.last_error = i2cmts_pkg::ERR_NONE;
              st_nxt.phase      = i2cmts_pkg::PH_IDLE;
            end
          end else begin
            res.action         = i2cmts_pkg::ACT_DATA;
            res.data_out       = item.next_write_byte;
            res.byte_index     = 16'(st.write_index);
            st_nxt.write_index = st.write_index + LEN_ONE;
          end
        end
        i2cmts_pkg::PH_READ: begin
          res.data_in       = item.received_byte;
          res.byte_index    = 16'(st.read_index);
          st_nxt.read_index = st.read_index + LEN_ONE;
          if (st.read_index == (st.read_total - LEN_ONE)) begin
            res.action        = i2cmts_pkg::ACT_NACK_STOP;
            res.done_res      = 1'b1;
            st_nxt.last_error = i2cmts_pkg::ERR_NONE;
            st_nxt.phase      = i2cmts_pkg::PH_IDLE;
          end else begin
            res.action = i2cmts_pkg::ACT_ACK;
          end
        end
        default: begin
          // idle or unused code: no action
        end
      endcase
    end
    res.error_code = st_nxt.last_error;
  end

endmodule

`default_nettype wire

/* rtl/i2c_master_transfer_sequencer.sv */
// Top level of the I2C master transfer sequencer.
// Depends on i2cmts_pkg and i2cmts_decide.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | kind, address, lengths, event flags, bytes
//   out_    | output    | out_valid/out_stall | accepted, action, bytes, index, error, done
//
// Every input word yields exactly one result word, in the cycle after acceptance.
// A word is taken every cycle in which in_stall is low; the only loop is the state register
// through the decision logic, one pass per word.
// in_stall rises only when the result register is full and out_stall holds it.
// Reset (rst_n low, synchronous) idles the sequencer and empties the result register.
`default_nettype none

module i2c_master_transfer_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request / bus event words
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [0:0]  in_kind,
  input  wire logic [6:0]  in_target_address,
  input  wire logic [15:0] in_write_length,
  input  wire logic [15:0] in_read_length,
  input  wire logic        in_read_first,
  input  wire logic        in_arbitration_lost,
  input  wire logic        in_bus_fault,
  input  wire logic        in_got_nack,
  input  wire logic [7:0]  in_received_byte,
  input  wire logic [7:0]  in_next_write_byte,
  // result words
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        out_accepted,
  output      logic [2:0]  out_action,
  output      logic [7:0]  out_address_byte,
  output      logic [7:0]  out_data_out,
  output      logic [7:0]  out_data_in,
  output      logic [15:0] out_byte_index,
  output      logic [1:0]  out_error_code,
  output      logic        out_done_res
);

  i2cmts_pkg::seq_state_t state_r;
  i2cmts_pkg::seq_state_t state_nxt;
  i2cmts_pkg::item_t      item;
  i2cmts_pkg::result_t    res_nxt;
  i2cmts_pkg::result_t    res_r;
  logic                   out_valid_r;
  logic                   in_take;

  // The result register frees up in the same cycle it is drained.
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  assign item = '{
    kind:             in_kind,
    target_address:   in_target_address,
    write_length:     in_write_length,
    read_length:      in_read_length,
    read_first:       in_read_first,
    arbitration_lost: in_arbitration_lost,
    bus_fault:        in_bus_fault,
    got_nack:         in_got_nack,
    received_byte:    in_received_byte,
    next_write_byte:  in_next_write_byte};

  i2cmts_decide u_decide (
    .st     (state_r),
    .item   (item),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  // Control: sequencer state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= i2cmts_pkg::STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: loaded only on acceptance, so it holds while stalled.
  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = res_r.accepted;
  assign out_action       = res_r.action;
  assign out_address_byte = res_r.address_byte;
  assign out_data_out     = res_r.data_out;
  assign out_data_in      = res_r.data_in;
  assign out_byte_index   = res_r.byte_index;
  assign out_error_code   = res_r.error_code;
  assign out_done_res     = res_r.done_res;

endmodule

`default_nettype wire

/* rtl/i2cmts_checker.sv */
// Port-level checker for the I2C master transfer sequencer, with its bind.
// Depends on i2cmts_pkg and i2c_master_transfer_sequencer_assert.svh.
`default_nettype none
`include "i2c_master_transfer_sequencer_assert.svh"

module i2cmts_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_accepted,
  input wire logic [2:0] out_action,
  input wire logic [1:0] out_error_code,
  input wire logic       out_done_res
);

  // a stalled result stays offered
  `I2CMTS_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_action))

  // done only on a stop of some kind
  `I2CMTS_ASSERT_IMP(a_done_stop, clk, rst_n, out_valid && out_done_res, (out_action == i2cmts_pkg::ACT_STOP) || (out_action == i2cmts_pkg::ACT_NACK_STOP))

  // an accepted start always sends the address and clears the error
  `I2CMTS_ASSERT_IMP(a_start_addr, clk, rst_n, out_valid && out_accepted, (out_action == i2cmts_pkg::ACT_ADDR) && (out_error_code == i2cmts_pkg::ERR_NONE) && !out_done_res)

  // final read byte is a clean end
  `I2CMTS_ASSERT_IMP(a_nack_end, clk, rst_n, out_valid && (out_action == i2cmts_pkg::ACT_NACK_STOP), out_done_res && (out_error_code == i2cmts_pkg::ERR_NONE))

  // error code range
  `I2CMTS_ASSERT(a_err_range, clk, rst_n, !out_valid || (out_error_code != 2'd3))

endmodule

bind i2c_master_transfer_sequencer i2cmts_checker u_i2cmts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_accepted   (out_accepted),
  .out_action     (out_action),
  .out_error_code (out_error_code),
  .out_done_res   (out_done_res)
);

`default_nettype wire
